// File: src/assert_macros.svh
// -----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; expect clk and rst_n in scope.
// -----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define NSTP_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define NSTP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/nstp_pkg.sv
// -----------------------------------------------------------------------------
// nstp_pkg
// Field widths, request codes and shared types of the scope time profiler.
// -----------------------------------------------------------------------------
package nstp_pkg;

  localparam int REQ_W      = 2;
  localparam int TYPE_W     = 6;
  localparam int TS_W       = 64;
  localparam int DUR_W      = 64;
  localparam int SWC_W      = 32;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 6;

  localparam int STACK_DEPTH_DEF   = 16;
  localparam int HISTORY_SLOTS_DEF = 16;
  localparam int NUM_TYPES_DEF     = 64;

  typedef enum logic [REQ_W-1:0] {
    REQ_START   = 2'd0,
    REQ_STOP    = 2'd1,
    REQ_READ    = 2'd2,
    REQ_ADVANCE = 2'd3
  } req_t;

  localparam logic [CFG_IDX_W-1:0] CFG_DEV_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEV_LAST  = 1'b1;

  localparam logic [CFG_DATA_W-1:0] DEV_FIRST_RST = 6'd0;
  localparam logic [CFG_DATA_W-1:0] DEV_LAST_RST  = 6'd31;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage

// File: src/nstp_div.sv
// -----------------------------------------------------------------------------
// nstp_div
// Division by a constant through reciprocal multiplication, four steps from
// start to done: load, low partial product, high partial product, final sum.
// -----------------------------------------------------------------------------
module nstp_div #(
  parameter int N       = 36,
  parameter int DIVISOR = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [N-1:0]              dividend,
  output logic [N-1:0]              quotient,
  output nstp_pkg::div_status_t     stat
);
  import nstp_pkg::*;

  // floor(x / DIVISOR) == (x * RECIP) >> SH for every x below 2^N
  localparam int SH = N + $clog2(DIVISOR);
  localparam int MW = N + 1;
  localparam int HW = (MW + 1) / 2;
  localparam int PW = N + HW;
  localparam int FW = PW + HW;
  localparam logic [63:0] RECIP =
    ((64'd1 << SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
  localparam logic [HW-1:0]    M_LO = RECIP[HW-1:0];
  localparam logic [MW-HW-1:0] M_HI = RECIP[MW-1:HW];

  typedef enum logic [3:0] {
    DV_IDLE = 4'b0001,
    DV_LO   = 4'b0010,
    DV_HI   = 4'b0100,
    DV_SUM  = 4'b1000
  } div_state_t;

  div_state_t    state_r, state_nxt;
  logic          done_r, done_nxt;
  logic [N-1:0]  x_r, x_nxt;
  logic [PW-1:0] lo_r, lo_nxt;
  logic [PW-1:0] hi_r, hi_nxt;
  logic [N-1:0]  q_r, q_nxt;
  logic [HW-1:0] mul_b;
  logic [PW-1:0] prod;
  logic [FW-1:0] full;

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    x_nxt     = x_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    q_nxt     = q_r;
    // one multiplier, shared by the two halves of the reciprocal
    mul_b     = (state_r == DV_HI) ? HW'(M_HI) : M_LO;
    prod      = PW'(x_r) * PW'(mul_b);
    full      = {hi_r, {HW{1'b0}}} + FW'(lo_r);
    case (state_r)
      DV_IDLE: begin
        if (start) begin
          x_nxt     = dividend;
          state_nxt = DV_LO;
        end
      end
      DV_LO: begin
        lo_nxt    = prod;
        state_nxt = DV_HI;
      end
      DV_HI: begin
        hi_nxt    = prod;
        state_nxt = DV_SUM;
      end
      DV_SUM: begin
        q_nxt     = N'(full >> SH);
        done_nxt  = 1'b1;
        state_nxt = DV_IDLE;
      end
      default: state_nxt = DV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r  <= x_nxt;
    lo_r <= lo_nxt;
    hi_r <= hi_nxt;
    q_r  <= q_nxt;
  end

  assign quotient  = q_r;
  assign stat.busy = (state_r != DV_IDLE);
  assign stat.done = done_r;

endmodule

// File: src/nested_scope_time_profiler_core.sv
// -----------------------------------------------------------------------------
// nested_scope_time_profiler_core
// Exclusive-time accounting for nested scopes, kept per history slot.
// -----------------------------------------------------------------------------
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | req_type, scope_type, timestamp
//  out     | out_valid/out_stall| status, total_duration, avg_switches, data_ready
//  cfg     | cfg_we             | cfg_idx, cfg_wdata (device type range)
//
//  Start and stop are accepted with the duration and stack reads, then written
//  back; rejected or ignored requests go from accept to the result load.
//  Advance wipes all 2^clog2(NUM_TYPES) duration entries of the new slot. Read
//  runs accept, a slot sweep, a reciprocal divide and the result load.
//  After reset the duration memory is cleared one entry a cycle, all DUR_DEPTH
//  entries (1024 by default). A held result stalls the final step.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"

module nested_scope_time_profiler_core #(
  parameter int STACK_DEPTH   = nstp_pkg::STACK_DEPTH_DEF,
  parameter int HISTORY_SLOTS = nstp_pkg::HISTORY_SLOTS_DEF,
  parameter int NUM_TYPES     = nstp_pkg::NUM_TYPES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [nstp_pkg::REQ_W-1:0]       in_req_type,
  input  logic [nstp_pkg::TYPE_W-1:0]      in_scope_type,
  input  logic [nstp_pkg::TS_W-1:0]        in_timestamp,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_status,
  output logic [nstp_pkg::DUR_W-1:0]       out_total_duration,
  output logic [nstp_pkg::SWC_W-1:0]       out_avg_switches,
  output logic                             out_data_ready,
  input  logic                             cfg_we,
  input  logic [nstp_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [nstp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import nstp_pkg::*;

  localparam int TW        = $clog2(NUM_TYPES);
  localparam int SLOT_W    = (HISTORY_SLOTS > 1) ? $clog2(HISTORY_SLOTS) : 1;
  localparam int SP_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W     = $clog2(STACK_DEPTH + 1);
  localparam int DUR_AW    = SLOT_W + TW;
  localparam int DUR_DEPTH = 1 << DUR_AW;
  localparam int SW_DEPTH  = 1 << SLOT_W;
  localparam int SUM_W     = SWC_W + $clog2(HISTORY_SLOTS);
  localparam int RD_W      = $clog2(HISTORY_SLOTS + 1);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_WB    = 7'b0000100,
    ST_SUM   = 7'b0001000,
    ST_DIV   = 7'b0010000,
    ST_WIPE  = 7'b0100000,
    ST_FIN   = 7'b1000000
  } state_t;

  // control state
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [SLOT_W-1:0]     slot_r, slot_nxt;
  logic                  ready_r, ready_nxt;
  logic [DUR_AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic [CFG_DATA_W-1:0] dev_first_r, dev_last_r;
  logic                  out_valid_r;

  // working registers
  logic [TW-1:0]         top_type_r, top_type_nxt;
  logic [TS_W-1:0]       top_start_r, top_start_nxt;
  logic [TW-1:0]         wipe_r, wipe_nxt;
  logic [RD_W-1:0]       iter_r, iter_nxt;
  logic                  acc_v_r, acc_v_nxt;
  logic [DUR_W-1:0]      tot_r, tot_nxt;
  logic [SUM_W-1:0]      sw_sum_r, sw_sum_nxt;
  req_t                  req_r, req_nxt;
  logic [TW-1:0]         type_idx_r, type_idx_nxt;
  logic                  type_ok_r, type_ok_nxt;
  logic                  dev_hit_r, dev_hit_nxt;
  logic [TS_W-1:0]       ts_r, ts_nxt;
  logic [DUR_W-1:0]      elapsed_r, elapsed_nxt;
  logic                  status_r, status_nxt;

  // output register payload
  logic                  out_status_r;
  logic [DUR_W-1:0]      out_total_r;
  logic [SWC_W-1:0]      out_avg_r;
  logic                  out_ready_r;

  // memories
  logic [DUR_W-1:0]      dur_mem [DUR_DEPTH];
  logic [SWC_W-1:0]      sw_mem  [SW_DEPTH];
  logic [TW-1:0]         stk_mem [STACK_DEPTH];

  logic                  dur_we;
  logic [DUR_AW-1:0]     dur_waddr, dur_raddr;
  logic [DUR_W-1:0]      dur_wdata, dur_rdata_r;
  logic                  sw_we;
  logic [SLOT_W-1:0]     sw_waddr, sw_raddr;
  logic [SWC_W-1:0]      sw_wdata, sw_rdata_r;
  logic                  stk_we;
  logic [SP_W-1:0]       stk_waddr, stk_raddr;
  logic [TW-1:0]         stk_wdata, stk_rdata_r;

  logic                  acc_in;
  logic                  out_free;
  logic                  load_out;
  req_t                  req_in;
  logic                  type_ok_in;
  logic                  dev_hit_in;
  logic [SLOT_W-1:0]     slot_inc;

  logic                  div_start;
  logic [SUM_W-1:0]      div_quot;
  div_status_t           div_stat;

  assign in_stall   = (state_r != ST_IDLE);
  assign acc_in     = in_valid && !in_stall;
  assign out_free   = !out_valid_r || !out_stall;
  assign req_in     = req_t'(in_req_type);
  assign type_ok_in = (16'(in_scope_type) < 16'(NUM_TYPES));
  assign dev_hit_in = (in_scope_type >= dev_first_r) && (in_scope_type <= dev_last_r);
  assign slot_inc   = (slot_r == SLOT_W'(HISTORY_SLOTS - 1)) ? '0 : slot_r + SLOT_W'(1);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    slot_nxt      = slot_r;
    ready_nxt     = ready_r;
    clr_addr_nxt  = clr_addr_r;
    top_type_nxt  = top_type_r;
    top_start_nxt = top_start_r;
    wipe_nxt      = wipe_r;
    iter_nxt      = iter_r;
    acc_v_nxt     = acc_v_r;
    tot_nxt       = tot_r;
    sw_sum_nxt    = sw_sum_r;
    req_nxt       = req_r;
    type_idx_nxt  = type_idx_r;
    type_ok_nxt   = type_ok_r;
    dev_hit_nxt   = dev_hit_r;
    ts_nxt        = ts_r;
    elapsed_nxt   = elapsed_r;
    status_nxt    = status_r;
    div_start     = 1'b0;
    load_out      = 1'b0;

    dur_we    = 1'b0;
    dur_waddr = {slot_r, top_type_r};
    dur_wdata = '0;
    dur_raddr = {slot_r, top_type_r};
    sw_we     = 1'b0;
    sw_waddr  = slot_r;
    sw_wdata  = '0;
    sw_raddr  = slot_r;
    stk_we    = 1'b0;
    stk_waddr = SP_W'(count_r - CNT_W'(1));
    stk_wdata = top_type_r;
    stk_raddr = SP_W'(count_r - CNT_W'(2));

    case (state_r)
      ST_CLEAR: begin
        dur_we       = 1'b1;
        dur_waddr    = clr_addr_r;
        sw_we        = 1'b1;
        sw_waddr     = clr_addr_r[SLOT_W-1:0];
        clr_addr_nxt = clr_addr_r + DUR_AW'(1);
        if (clr_addr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (acc_in) begin
          // reads of duration entry, switch count and next stack entry go out now
          req_nxt      = req_in;
          type_idx_nxt = TW'(in_scope_type);
          type_ok_nxt  = type_ok_in;
          dev_hit_nxt  = dev_hit_in;
          ts_nxt       = in_timestamp;
          elapsed_nxt  = in_timestamp - top_start_r;
          status_nxt   = STATUS_OK;
          case (req_in)
            REQ_START: begin
              if (count_r == CNT_W'(STACK_DEPTH)) begin
                status_nxt = STATUS_OVERFLOW;
                state_nxt  = ST_FIN;
              end else if (!type_ok_in) begin
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_WB;
              end
            end
            REQ_STOP: begin
              state_nxt = (count_r == '0) ? ST_FIN : ST_WB;
            end
            REQ_READ: begin
              iter_nxt   = '0;
              acc_v_nxt  = 1'b0;
              tot_nxt    = '0;
              sw_sum_nxt = '0;
              state_nxt  = ST_SUM;
            end
            REQ_ADVANCE: begin
              slot_nxt = slot_inc;
              if (slot_inc == '0) begin
                ready_nxt = 1'b1;
              end
              wipe_nxt  = '0;
              state_nxt = ST_WIPE;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_WB: begin
        case (req_r)
          REQ_START: begin
            if (count_r != '0) begin
              dur_we    = 1'b1;
              dur_wdata = dur_rdata_r + elapsed_r;
              stk_we    = 1'b1;
            end
            if (dev_hit_r) begin
              sw_we    = 1'b1;
              sw_wdata = sw_rdata_r + SWC_W'(1);
            end
            top_type_nxt  = type_idx_r;
            top_start_nxt = ts_r;
            count_nxt     = count_r + CNT_W'(1);
          end
          REQ_STOP: begin
            dur_we    = 1'b1;
            dur_wdata = dur_rdata_r + elapsed_r;
            count_nxt = count_r - CNT_W'(1);
            if (count_r > CNT_W'(1)) begin
              top_type_nxt = stk_rdata_r;
            end
            top_start_nxt = ts_r;
          end
          default: ;
        endcase
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_SUM: begin
        // one slot read per cycle, accumulated in the cycle after its read
        if (iter_r != RD_W'(HISTORY_SLOTS)) begin
          dur_raddr = {SLOT_W'(iter_r), type_idx_r};
          sw_raddr  = SLOT_W'(iter_r);
          iter_nxt  = iter_r + RD_W'(1);
          acc_v_nxt = 1'b1;
        end else begin
          acc_v_nxt = 1'b0;
        end
        if (acc_v_r) begin
          if (type_ok_r) begin
            tot_nxt = tot_r + dur_rdata_r;
          end
          sw_sum_nxt = sw_sum_r + SUM_W'(sw_rdata_r);
        end
        if (iter_r == RD_W'(HISTORY_SLOTS) && !acc_v_r) begin
          div_start = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_WIPE: begin
        dur_we    = 1'b1;
        dur_waddr = {slot_r, wipe_r};
        sw_we     = 1'b1;
        sw_waddr  = slot_r;
        wipe_nxt  = wipe_r + TW'(1);
        if (wipe_r == '1) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      count_r     <= '0;
      slot_r      <= '0;
      ready_r     <= 1'b0;
      clr_addr_r  <= '0;
      dev_first_r <= DEV_FIRST_RST;
      dev_last_r  <= DEV_LAST_RST;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      slot_r     <= slot_nxt;
      ready_r    <= ready_nxt;
      clr_addr_r <= clr_addr_nxt;
      if (cfg_we) begin
        case (cfg_idx)
          CFG_DEV_FIRST: dev_first_r <= cfg_wdata;
          CFG_DEV_LAST:  dev_last_r  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    top_type_r  <= top_type_nxt;
    top_start_r <= top_start_nxt;
    wipe_r      <= wipe_nxt;
    iter_r      <= iter_nxt;
    acc_v_r     <= acc_v_nxt;
    tot_r       <= tot_nxt;
    sw_sum_r    <= sw_sum_nxt;
    req_r       <= req_nxt;
    type_idx_r  <= type_idx_nxt;
    type_ok_r   <= type_ok_nxt;
    dev_hit_r   <= dev_hit_nxt;
    ts_r        <= ts_nxt;
    elapsed_r   <= elapsed_nxt;
    status_r    <= status_nxt;
  end

  // duration accounts, one entry per slot and type
  always_ff @(posedge clk) begin
    if (dur_we) begin
      dur_mem[dur_waddr] <= dur_wdata;
    end
    dur_rdata_r <= dur_mem[dur_raddr];
  end

  // context switch count per slot
  always_ff @(posedge clk) begin
    if (sw_we) begin
      sw_mem[sw_waddr] <= sw_wdata;
    end
    sw_rdata_r <= sw_mem[sw_raddr];
  end

  // types of open scopes below the top one
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rdata_r <= stk_mem[stk_raddr];
  end

  nstp_div #(
    .N       (SUM_W),
    .DIVISOR (HISTORY_SLOTS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sw_sum_r),
    .quotient (div_quot),
    .stat     (div_stat)
  );

  // result register; a new transfer may be accepted while it is held
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_total_r  <= (req_r == REQ_READ) ? tot_r : '0;
      out_avg_r    <= (req_r == REQ_READ) ? div_quot[SWC_W-1:0] : '0;
      out_ready_r  <= ready_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_total_duration = out_total_r;
  assign out_avg_switches   = out_avg_r;
  assign out_data_ready     = out_ready_r;

  `NSTP_ASSERT_NEXT(a_full_push_keeps_depth, acc_in && req_in == REQ_START && count_r == CNT_W'(STACK_DEPTH), count_r == $past(count_r) && state_r == ST_FIN, "rejected push changed stack depth")
  `NSTP_ASSERT_NEXT(a_push_grows_stack, state_r == ST_WB && req_r == REQ_START, count_r == $past(count_r) + CNT_W'(1), "push did not grow stack by one")
  `NSTP_ASSERT_SAME(a_div_done_in_div, div_stat.done, state_r == ST_DIV, "divider finished outside the read sequence")

endmodule

// File: bench/tb.sv
// -----------------------------------------------------------------------------
// tb
// Checks the scope time profiler core against a cycle-free predictor of its
// stack, per-slot duration and switch accounts. A directed table covers the
// reset state, empty-stack stop, stack overflow, timestamp extremes and slot
// advance; random start, stop, read and advance traffic then runs under several device ranges.
// -----------------------------------------------------------------------------
module tb;
  import nstp_pkg::*;

  localparam int STACK_DEPTH = STACK_DEPTH_DEF;
  localparam int HIST        = HISTORY_SLOTS_DEF;
  localparam int NTYPES      = NUM_TYPES_DEF;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 305;
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic               status;
    logic [DUR_W-1:0]   total;
    logic [SWC_W-1:0]   avg;
    logic               ready;
  } prof_result_t;

  typedef struct {
    req_t              req;
    logic [TYPE_W-1:0] stype;
    logic [TS_W-1:0]   ts;
    bit                typed;
    prof_result_t      want;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [REQ_W-1:0]      in_req_type = '0;
  logic [TYPE_W-1:0]     in_scope_type = '0;
  logic [TS_W-1:0]       in_timestamp = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_status;
  logic [DUR_W-1:0]      out_total_duration;
  logic [SWC_W-1:0]      out_avg_switches;
  logic                  out_data_ready;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  nested_scope_time_profiler_core dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [TYPE_W-1:0] open_type  [STACK_DEPTH];
  logic [TS_W-1:0]   open_since [STACK_DEPTH];
  int                depth;
  logic [DUR_W-1:0]  dur [HIST][NTYPES];
  logic [SWC_W-1:0]  switch_cnt [HIST];
  int                slot;
  logic              ready;
  logic [5:0]        dev_first, dev_last;

  prof_result_t pending_results[$];
  dir_row_t     dir_tab[$];
  int           errors = 0;
  int           src_idle = 17;
  int           rcv_idle = 79;
  int           quiet_cycles = 0;

  function automatic prof_result_t profile_step(req_t r, logic [TYPE_W-1:0] t,
                                                logic [TS_W-1:0] now);
    prof_result_t res;
    logic [63:0]  sw_sum;
    res = '0;
    case (r)
      REQ_START: begin
        if (depth == STACK_DEPTH) begin
          res.status = STATUS_OVERFLOW;
        end else begin
          if (t >= dev_first && t <= dev_last) switch_cnt[slot] += 1;
          if (depth > 0) dur[slot][open_type[depth-1]] += now - open_since[depth-1];
          open_type[depth]  = t;
          open_since[depth] = now;
          depth++;
        end
      end
      REQ_STOP: begin
        if (depth > 0) begin
          depth--;
          dur[slot][open_type[depth]] += now - open_since[depth];
          // enclosing scope restarts its timing here
          if (depth > 0) open_since[depth-1] = now;
        end
      end
      REQ_READ: begin
        sw_sum = '0;
        for (int s = 0; s < HIST; s++) begin
          res.total += dur[s][t];
          sw_sum    += 64'(switch_cnt[s]);
        end
        res.avg = SWC_W'(sw_sum / HIST);
      end
      default: begin
        slot = (slot + 1) % HIST;
        for (int k = 0; k < NTYPES; k++) dur[slot][k] = '0;
        switch_cnt[slot] = '0;
        if (slot == 0) ready = 1'b1;
      end
    endcase
    res.ready = ready;
    return res;
  endfunction

  function automatic void add_row(req_t r, logic [TYPE_W-1:0] t, logic [TS_W-1:0] ts,
                                  bit typed, prof_result_t want);
    dir_row_t row;
    row.req   = r;
    row.stype = t;
    row.ts    = ts;
    row.typed = typed;
    row.want  = want;
    dir_tab.push_back(row);
  endfunction

  task automatic send(req_t r, logic [TYPE_W-1:0] t, logic [TS_W-1:0] ts,
                      bit typed, prof_result_t want);
    prof_result_t predicted;
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= r;
    in_scope_type <= t;
    in_timestamp  <= ts;
    do @(posedge clk); while (in_stall);
    predicted = profile_step(r, t, ts);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_device_range(logic [5:0] first, logic [5:0] last);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_DEV_FIRST;
    cfg_wdata <= first;
    @(posedge clk);
    cfg_idx   <= CFG_DEV_LAST;
    cfg_wdata <= last;
    @(posedge clk);
    cfg_we    <= 1'b0;
    dev_first = first;
    dev_last  = last;
  endtask

  // result transfers checked in order; receiver stall drawn per cycle
  always @(posedge clk) begin : result_check
    prof_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: status %0d total %0h avg %0d ready %0d",
               out_status, out_total_duration, out_avg_switches, out_data_ready);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_status);
          errors++;
        end
        if (out_total_duration !== want.total) begin
          $error("total_duration: expected %0h, got %0h", want.total, out_total_duration);
          errors++;
        end
        if (out_avg_switches !== want.avg) begin
          $error("avg_switches: expected %0d, got %0d", want.avg, out_avg_switches);
          errors++;
        end
        if (out_data_ready !== want.ready) begin
          $error("data_ready: expected %0d, got %0d", want.ready, out_data_ready);
          errors++;
        end
      end
    end
    out_stall <= ($urandom_range(0, 99) < rcv_idle);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("** nested_scope_time_profiler_core: FAILED **");
      $finish;
    end
  end

  initial begin
    req_t        r;
    logic [63:0] clock_now, ts;
    logic [5:0]  first, last;
    int          pick, fill_left;

    depth     = 0;
    slot      = 0;
    ready     = 1'b0;
    dev_first = DEV_FIRST_RST;
    dev_last  = DEV_LAST_RST;
    for (int s = 0; s < HIST; s++) begin
      switch_cnt[s] = '0;
      for (int k = 0; k < NTYPES; k++) dur[s][k] = '0;
    end

    // directed table, reset device range
    add_row(REQ_READ, 6'd0, 64'd0, 1'b1, {STATUS_OK, 64'd0, 32'd0, 1'b0});
    add_row(REQ_STOP, 6'd0, '1, 1'b1, {STATUS_OK, 64'd0, 32'd0, 1'b0});
    for (int i = 0; i < STACK_DEPTH; i++)
      add_row(REQ_START, (i == 0) ? 6'd0 : (i == 1) ? 6'd63 : (i == 2) ? 6'd31 :
              (i == 3) ? 6'd32 : 6'(i * 4 + 1), 64'(i * 1000 + 7), 1'b0, '0);
    // full stack: push rejected
    add_row(REQ_START, 6'd5, 64'd99999, 1'b1, {STATUS_OVERFLOW, 64'd0, 32'd0, 1'b0});
    add_row(REQ_READ, 6'd0, 64'd0, 1'b0, '0);
    add_row(REQ_STOP, 6'd0, '1, 1'b0, '0);
    add_row(REQ_READ, 6'd61, 64'd0, 1'b0, '0);
    add_row(REQ_ADVANCE, 6'd0, 64'd0, 1'b0, '0);
    // earlier than the restart stamp: elapsed time wraps
    add_row(REQ_STOP, 6'd0, 64'd0, 1'b0, '0);
    add_row(REQ_READ, 6'd63, 64'd0, 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i])
      send(dir_tab[i].req, dir_tab[i].stype, dir_tab[i].ts, dir_tab[i].typed, dir_tab[i].want);

    fill_left = 0;
    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0: begin first = 6'd0;  last = 6'd63; end
        1: begin first = 6'd63; last = 6'd0;  end   // empty range
        2: begin first = 6'd10; last = 6'd40; end
        3: begin first = 6'd63; last = 6'd63; end
        4: begin first = 6'd0;  last = 6'd0;  end
        default: begin first = 6'($urandom); last = 6'($urandom); end
      endcase
      set_device_range(first, last);
      src_idle  = (p < 2) ? 17 : (p < 4) ? 79 : 0;
      rcv_idle  = (p < 2) ? 79 : (p < 4) ? 17 : 0;
      clock_now = {$urandom, $urandom};
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 0 && n == PHASE_ITEMS / 2) drain();
        // occasional burst of starts to run the stack into overflow
        if (fill_left == 0 && $urandom_range(0, 99) < 2) fill_left = 20;
        pick = $urandom_range(0, 99);
        if (fill_left > 0) begin
          r = REQ_START;
          fill_left--;
        end else if (pick < 40) r = REQ_START;
        else if (pick < 85) r = REQ_STOP;
        else if (pick < 93) r = REQ_READ;
        else r = REQ_ADVANCE;
        if ($urandom_range(0, 99) < 4) clock_now = {$urandom, $urandom};
        else clock_now += 64'($urandom_range(0, 2000));
        ts = ($urandom_range(0, 99) < 3) ? {$urandom, $urandom} : clock_now;
        send(r, 6'($urandom_range(0, 63)), ts, 1'b0, '0);
      end
    end

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0)
      $display("** nested_scope_time_profiler_core: PASSED **");
    else
      $display("** nested_scope_time_profiler_core: FAILED **");
    $finish;
  end

endmodule
